FILE: design/srd_pkg.sv
// Shared constants for the radial deadzone stick core: register indexes,
// datapath widths and pipeline latencies. Depends on nothing.
`default_nettype none
package srd_pkg;

	localparam int AXIS_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SENS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DZ     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y  = 3'd4;

	localparam logic [6:0]  SENS_RST  = 7'd10;
	localparam logic [7:0]  RANGE_RST = 8'd100;
	localparam logic [7:0]  RANGE_MIN = 8'd50;
	localparam logic [7:0]  RANGE_MAX = 8'd150;
	localparam logic [16:0] ONE_Q16   = 17'h10000;

	// Pipelined restoring divider.
	localparam int DN_W    = 50;
	localparam int DD_W    = 34;
	localparam int DQ_W    = 34;
	localparam int DIV_LAT = DQ_W + 1;

	// Pipelined integer square root.
	localparam int SQ_IN_W  = 64;
	localparam int SQ_STEPS = 32;
	localparam int SQ_RES_W = 32;
	localparam int SQ_LAT   = SQ_STEPS + 1;

endpackage
`default_nettype wire

FILE: design/srd_stream_if.sv
// Valid/ready channel interfaces for the stick core: raw axis samples in,
// stick positions out. Depends on srd_pkg.
`default_nettype none
interface srd_in_if;
	logic valid;
	logic ready;
	logic signed [srd_pkg::AXIS_W-1:0] raw_x;
	logic signed [srd_pkg::AXIS_W-1:0] raw_y;
	modport source(output valid, output raw_x, output raw_y, input ready);
	modport sink(input valid, input raw_x, input raw_y, output ready);
endinterface

interface srd_out_if;
	logic valid;
	logic ready;
	logic signed [srd_pkg::AXIS_W-1:0] out_x;
	logic signed [srd_pkg::AXIS_W-1:0] out_y;
	modport source(output valid, output out_x, output out_y, input ready);
	modport sink(input valid, input out_x, input out_y, output ready);
endinterface
`default_nettype wire

FILE: design/srd_div_pipe.sv
// Fully pipelined restoring divider, one quotient bit per stage, with an
// overflow check at entry that saturates the quotient. Depends on srd_pkg.
`default_nettype none
module srd_div_pipe (
	input  logic clk,
	input  logic en,
	input  logic [srd_pkg::DN_W-1:0] num,
	input  logic [srd_pkg::DD_W-1:0] den,
	output logic [srd_pkg::DQ_W-1:0] quo
);
	import srd_pkg::*;

	localparam int CW = DN_W + DQ_W + DD_W;

	logic [DN_W-1:0] rem_q [DQ_W+1];
	logic [DD_W-1:0] den_q [DQ_W+1];
	logic [DQ_W-1:0] quo_q [DQ_W+1];
	logic            ovf_q [DQ_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num;
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= CW'(num) >= (CW'(den) << DQ_W);
			for (int j = 0; j < DQ_W; j++) begin
				// Stage j resolves quotient bit DQ_W-1-j.
				if (CW'(rem_q[j]) >= (CW'(den_q[j]) << (DQ_W - 1 - j))) begin
					rem_q[j+1] <= rem_q[j] - DN_W'(CW'(den_q[j]) << (DQ_W - 1 - j));
					quo_q[j+1] <= quo_q[j] | (DQ_W'(1) << (DQ_W - 1 - j));
				end else begin
					rem_q[j+1] <= rem_q[j];
					quo_q[j+1] <= quo_q[j];
				end
				den_q[j+1] <= den_q[j];
				ovf_q[j+1] <= ovf_q[j];
			end
		end
	end

	assign quo = ovf_q[DQ_W] ? '1 : quo_q[DQ_W];

endmodule
`default_nettype wire

FILE: design/srd_sqrt_pipe.sv
// Fully pipelined integer square root, one result bit per stage (floor).
// Depends on srd_pkg.
`default_nettype none
module srd_sqrt_pipe (
	input  logic clk,
	input  logic en,
	input  logic [srd_pkg::SQ_IN_W-1:0] val,
	output logic [srd_pkg::SQ_RES_W-1:0] root
);
	import srd_pkg::*;

	logic [SQ_IN_W-1:0] v_q   [SQ_STEPS+1];
	logic [SQ_IN_W-1:0] res_q [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			v_q[0]   <= val;
			res_q[0] <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				// The trial bit of stage k is 4^(SQ_STEPS-1-k).
				if (v_q[k] >= res_q[k] + (SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k))) begin
					v_q[k+1]   <= v_q[k] - res_q[k] - (SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k));
					res_q[k+1] <= (res_q[k] >> 1) + (SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k));
				end else begin
					v_q[k+1]   <= v_q[k];
					res_q[k+1] <= res_q[k] >> 1;
				end
			end
		end
	end

	assign root = res_q[SQ_STEPS][SQ_RES_W-1:0];

endmodule
`default_nettype wire

FILE: design/stick_radial_deadzone_core.sv
// Top level of the radial deadzone stick core: scaling, clamp to the unit
// circle and radial deadzone. Depends on srd_pkg, srd_stream_if, srd_div_pipe, srd_sqrt_pipe.
//
//   channel  dir  handshake      payload
//   samp     in   valid/ready    raw_x, raw_y (signed 16)
//   stick    out  valid/ready    out_x, out_y (signed Q1.15)
//   cfg      in   cfg_we         cfg_idx, cfg_data
//
// One beat is accepted per cycle while the output is not stalled. The path runs through three
// pairs of 35-stage dividers, two 33-stage square roots and the surrounding multiply stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline at once; nothing is dropped.
`default_nettype none
module stick_radial_deadzone_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
	srd_in_if.sink samp,
	srd_out_if.source stick
);
	import srd_pkg::*;

	typedef struct packed {
		logic nx;
		logic ny;
	} sgn_t;

	typedef struct packed {
		logic [29:0] mx;
		logic [29:0] my;
		logic        big;
		sgn_t        sg;
	} side1_t;

	typedef struct packed {
		logic [16:0] mx;
		logic [16:0] my;
		sgn_t        sg;
	} side2_t;

	typedef struct packed {
		logic zero;
		sgn_t sg;
	} side3_t;

	// Configuration.
	logic [6:0]  sens_q;
	logic [7:0]  range_q;
	logic [16:0] dz_q;
	logic        invx_q, invy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= SENS_RST;
			range_q <= RANGE_RST;
			dz_q    <= '0;
			invx_q  <= 1'b0;
			invy_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SENS:  sens_q  <= cfg_data[6:0];
				REG_RANGE: range_q <= cfg_data[7:0];
				REG_DZ:    dz_q    <= cfg_data;
				REG_INV_X: invx_q  <= cfg_data[0];
				REG_INV_Y: invy_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [7:0]  rp_c;
	logic [10:0] den10_c;
	logic [16:0] dzc_c;
	logic [16:0] one_m_dz_c;

	always_comb begin
		rp_c = range_q;
		if (range_q < RANGE_MIN) rp_c = RANGE_MIN;
		if (range_q > RANGE_MAX) rp_c = RANGE_MAX;
		den10_c    = 11'(rp_c) * 11'd10;
		dzc_c      = (dz_q > ONE_Q16) ? ONE_Q16 : dz_q;
		one_m_dz_c = ONE_Q16 - dzc_c;
	end

	logic adv;
	logic ovld_q;
	assign adv        = !ovld_q || stick.ready;
	assign samp.ready = adv;

	// S1: magnitudes and signs.
	logic        v_s1;
	logic [16:0] mx_s1, my_s1;
	sgn_t        sg_s1;
	// S2: scaling numerators.
	logic        v_s2;
	logic [DN_W-1:0] nx_s2, ny_s2;
	sgn_t        sg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1    <= samp.raw_x[15] ? ONE_Q16 - {1'b0, samp.raw_x} : {1'b0, samp.raw_x};
			my_s1    <= samp.raw_y[15] ? ONE_Q16 - {1'b0, samp.raw_y} : {1'b0, samp.raw_y};
			sg_s1.nx <= samp.raw_x[15] ^ invx_q;
			sg_s1.ny <= samp.raw_y[15] ^ invy_q;
			nx_s2    <= DN_W'({24'(mx_s1) * 24'(sens_q), 16'd0}) + DN_W'(den10_c >> 1);
			ny_s2    <= DN_W'({24'(my_s1) * 24'(sens_q), 16'd0}) + DN_W'(den10_c >> 1);
			sg_s2    <= sg_s1;
		end
	end

	logic [DQ_W-1:0] qa_x, qa_y;
	srd_div_pipe u_div_ax (.clk(clk), .en(adv), .num(nx_s2), .den(DD_W'(den10_c)), .quo(qa_x));
	srd_div_pipe u_div_ay (.clk(clk), .en(adv), .num(ny_s2), .den(DD_W'(den10_c)), .quo(qa_y));

	sgn_t               sa_d [DIV_LAT];
	logic [DIV_LAT-1:0] va_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_d[0] <= sg_s2;
			for (int i = 1; i < DIV_LAT; i++) sa_d[i] <= sa_d[i-1];
		end
	end

	// S3: squares of the scaled axes. S4: squared radius.
	logic        v_s3, v_s4;
	logic [29:0] mx_s3, my_s3, mx_s4, my_s4;
	logic [59:0] qx_s3, qy_s3;
	logic [60:0] r2_s4;
	logic        big_s4;
	sgn_t        sg_s3, sg_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s3  <= qa_x[29:0];
			my_s3  <= qa_y[29:0];
			qx_s3  <= qa_x[29:0] * qa_x[29:0];
			qy_s3  <= qa_y[29:0] * qa_y[29:0];
			sg_s3  <= sa_d[DIV_LAT-1];
			mx_s4  <= mx_s3;
			my_s4  <= my_s3;
			r2_s4  <= 61'(qx_s3) + 61'(qy_s3);
			big_s4 <= (61'(qx_s3) + 61'(qy_s3)) > (61'(1) << 32);
			sg_s4  <= sg_s3;
		end
	end

	logic [SQ_RES_W-1:0] r1;
	srd_sqrt_pipe u_sqrt_1 (.clk(clk), .en(adv), .val(SQ_IN_W'(r2_s4)), .root(r1));

	side1_t            sb_d [SQ_LAT];
	logic [SQ_LAT-1:0] vb_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_d[0] <= '{mx: mx_s4, my: my_s4, big: big_s4, sg: sg_s4};
			for (int i = 1; i < SQ_LAT; i++) sb_d[i] <= sb_d[i-1];
		end
	end

	// S5: normalize onto the unit circle; a short vector divides by one.
	logic            v_s5;
	logic [DN_W-1:0] nx_s5, ny_s5;
	logic [DD_W-1:0] dn_s5;
	sgn_t            sg_s5;
	side1_t          sb_o;
	assign sb_o = sb_d[SQ_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sb_o.big) begin
				nx_s5 <= DN_W'({sb_o.mx, 16'd0}) + DN_W'(r1 >> 1);
				ny_s5 <= DN_W'({sb_o.my, 16'd0}) + DN_W'(r1 >> 1);
				dn_s5 <= DD_W'(r1);
			end else begin
				nx_s5 <= DN_W'(sb_o.mx);
				ny_s5 <= DN_W'(sb_o.my);
				dn_s5 <= DD_W'(1);
			end
			sg_s5 <= sb_o.sg;
		end
	end

	logic [DQ_W-1:0] qb_x, qb_y;
	srd_div_pipe u_div_bx (.clk(clk), .en(adv), .num(nx_s5), .den(dn_s5), .quo(qb_x));
	srd_div_pipe u_div_by (.clk(clk), .en(adv), .num(ny_s5), .den(dn_s5), .quo(qb_y));

	sgn_t               sc_d [DIV_LAT];
	logic [DIV_LAT-1:0] vc_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_d[0] <= sg_s5;
			for (int i = 1; i < DIV_LAT; i++) sc_d[i] <= sc_d[i-1];
		end
	end

	// S6: squares of the clamped axes. S7: squared radius.
	logic        v_s6, v_s7;
	logic [16:0] mx_s6, my_s6, mx_s7, my_s7;
	logic [33:0] qx_s6, qy_s6;
	logic [34:0] r2_s7;
	sgn_t        sg_s6, sg_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s6 <= qb_x[16:0];
			my_s6 <= qb_y[16:0];
			qx_s6 <= qb_x[16:0] * qb_x[16:0];
			qy_s6 <= qb_y[16:0] * qb_y[16:0];
			sg_s6 <= sc_d[DIV_LAT-1];
			mx_s7 <= mx_s6;
			my_s7 <= my_s6;
			r2_s7 <= 35'(qx_s6) + 35'(qy_s6);
			sg_s7 <= sg_s6;
		end
	end

	logic [SQ_RES_W-1:0] r2root;
	srd_sqrt_pipe u_sqrt_2 (.clk(clk), .en(adv), .val(SQ_IN_W'(r2_s7)), .root(r2root));

	side2_t            sd_d [SQ_LAT];
	logic [SQ_LAT-1:0] vd_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_d[0] <= '{mx: mx_s7, my: my_s7, sg: sg_s7};
			for (int i = 1; i < SQ_LAT; i++) sd_d[i] <= sd_d[i-1];
		end
	end

	// S8: deadzone test and products. S9: rounded deadzone numerators.
	logic        v_s8, v_s9;
	logic [16:0] r_c, a_c;
	logic [33:0] px_s8, py_s8, dd_s8;
	logic        zero_s8, zero_s9;
	sgn_t        sg_s8, sg_s9;
	logic [DN_W-1:0] nx_s9, ny_s9;
	logic [DD_W-1:0] dd_s9;
	side2_t      sd_o;

	assign sd_o = sd_d[SQ_LAT-1];
	assign r_c  = r2root[16:0];
	assign a_c  = r_c - dzc_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s8 <= dzc_c[16] || (r_c <= dzc_c);
			px_s8   <= sd_o.mx * a_c;
			py_s8   <= sd_o.my * a_c;
			dd_s8   <= one_m_dz_c * r_c;
			sg_s8   <= sd_o.sg;
			nx_s9   <= DN_W'({px_s8, 15'd0}) + DN_W'(dd_s8 >> 1);
			ny_s9   <= DN_W'({py_s8, 15'd0}) + DN_W'(dd_s8 >> 1);
			dd_s9   <= DD_W'(dd_s8);
			zero_s9 <= zero_s8;
			sg_s9   <= sg_s8;
		end
	end

	logic [DQ_W-1:0] qd_x, qd_y;
	srd_div_pipe u_div_dx (.clk(clk), .en(adv), .num(nx_s9), .den(dd_s9), .quo(qd_x));
	srd_div_pipe u_div_dy (.clk(clk), .en(adv), .num(ny_s9), .den(dd_s9), .quo(qd_y));

	side3_t             se_d [DIV_LAT];
	logic [DIV_LAT-1:0] ve_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			se_d[0] <= '{zero: zero_s9, sg: sg_s9};
			for (int i = 1; i < DIV_LAT; i++) se_d[i] <= se_d[i-1];
		end
	end

	// Valid bits for every stage and delay line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			va_d <= '0; vb_d <= '0; vc_d <= '0; vd_d <= '0; ve_d <= '0;
			ovld_q <= 1'b0;
		end else if (adv) begin
			v_s1   <= samp.valid;
			v_s2   <= v_s1;
			va_d   <= {va_d[DIV_LAT-2:0], v_s2};
			v_s3   <= va_d[DIV_LAT-1];
			v_s4   <= v_s3;
			vb_d   <= {vb_d[SQ_LAT-2:0], v_s4};
			v_s5   <= vb_d[SQ_LAT-1];
			vc_d   <= {vc_d[DIV_LAT-2:0], v_s5};
			v_s6   <= vc_d[DIV_LAT-1];
			v_s7   <= v_s6;
			vd_d   <= {vd_d[SQ_LAT-2:0], v_s7};
			v_s8   <= vd_d[SQ_LAT-1];
			v_s9   <= v_s8;
			ve_d   <= {ve_d[DIV_LAT-2:0], v_s9};
			ovld_q <= ve_d[DIV_LAT-1];
		end
	end

	// Output register: saturate to Q1.15 and apply the sign.
	logic [AXIS_W-1:0] ox_q, oy_q;
	side3_t            se_o;
	assign se_o = se_d[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (se_o.zero) begin
				ox_q <= '0;
			end else if (se_o.sg.nx) begin
				ox_q <= (qd_x > DQ_W'(32768)) ? 16'h8000 : AXIS_W'(17'h10000 - 17'(qd_x));
			end else begin
				ox_q <= (qd_x > DQ_W'(32767)) ? 16'h7FFF : AXIS_W'(qd_x);
			end
			if (se_o.zero) begin
				oy_q <= '0;
			end else if (se_o.sg.ny) begin
				oy_q <= (qd_y > DQ_W'(32768)) ? 16'h8000 : AXIS_W'(17'h10000 - 17'(qd_y));
			end else begin
				oy_q <= (qd_y > DQ_W'(32767)) ? 16'h7FFF : AXIS_W'(qd_y);
			end
		end
	end

	assign stick.valid = ovld_q;
	assign stick.out_x = ox_q;
	assign stick.out_y = oy_q;

endmodule
`default_nettype wire

FILE: design/srd_checker.sv
// Port-level checks for the stick core, attached by bind.
// Depends on srd_pkg and stick_radial_deadzone_core.
`default_nettype none
module srd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [srd_pkg::AXIS_W-1:0] out_x,
	input logic [srd_pkg::AXIS_W-1:0] out_y
);
	import srd_pkg::*;

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
		else $error("stalled output beat changed");

	// With the output register empty the pipeline always takes a sample.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output empty");

	// A stalled output freezes the pipeline, so no sample may enter.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("sample accepted during output stall");

	// Nothing comes out right after reset without a sample going in.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output beat without input");

endmodule

bind stick_radial_deadzone_core srd_checker u_srd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samp.valid),
	.in_ready(samp.ready),
	.out_valid(stick.valid),
	.out_ready(stick.ready),
	.out_x(stick.out_x),
	.out_y(stick.out_y)
);
`default_nettype wire
